### src/mkd_pkg.sv
`default_nettype none

package mkd_pkg;

  localparam int unsigned NUM_SLOTS   = 5;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned WORD_W      = NUM_SLOTS * SLOT_W;
  localparam int unsigned NUM_CHARS   = 36;
  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_DIGITS  = NUM_CHARS - NUM_LETTERS;

  localparam logic [6:0]  ASCII_A      = 7'd65;
  localparam logic [6:0]  ASCII_0      = 7'd48;
  localparam logic [2:0]  FULL_COUNT   = 3'(NUM_SLOTS);
  localparam logic [15:0] THRESH_RESET = 16'd200;

  typedef enum logic [1:0] {
    CMD_PRESS = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ELEM_NONE = 2'd0,
    ELEM_DOT  = 2'd1,
    ELEM_DASH = 2'd2
  } element_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [2:0]        count;
    logic              cleared;
  } mkd_state_t;

  // One result beat; rest holds the slots of a loaded pattern still to be sent.
  typedef struct packed {
    logic                     accepted;
    logic [SLOT_W-1:0]        element;
    logic [WORD_W-SLOT_W-1:0] rest;
    logic [2:0]               count;
    logic                     cleared;
    logic [6:0]               matched;
  } mkd_result_t;

  // Slot 0 sits in the low bits: {s4, s3, s2, s1, s0}, dot 01, dash 10.
  function automatic logic [WORD_W-1:0] char_pattern(input logic [5:0] idx);
    logic [WORD_W-1:0] p;
    unique case (idx)
      6'd0:    p = 10'b00_00_00_10_01; // A
      6'd1:    p = 10'b00_01_01_01_10; // B
      6'd2:    p = 10'b00_01_10_01_10; // C
      6'd3:    p = 10'b00_00_01_01_10; // D
      6'd4:    p = 10'b00_00_00_00_01; // E
      6'd5:    p = 10'b00_01_10_01_01; // F
      6'd6:    p = 10'b00_00_01_10_10; // G
      6'd7:    p = 10'b00_01_01_01_01; // H
      6'd8:    p = 10'b00_00_00_01_01; // I
      6'd9:    p = 10'b00_10_10_10_01; // J
      6'd10:   p = 10'b00_00_10_01_10; // K
      6'd11:   p = 10'b00_01_01_10_01; // L
      6'd12:   p = 10'b00_00_00_10_10; // M
      6'd13:   p = 10'b00_00_00_01_10; // N
      6'd14:   p = 10'b00_00_10_10_10; // O
      6'd15:   p = 10'b00_01_10_10_01; // P
      6'd16:   p = 10'b00_10_01_10_10; // Q
      6'd17:   p = 10'b00_00_01_10_01; // R
      6'd18:   p = 10'b00_00_01_01_01; // S
      6'd19:   p = 10'b00_00_00_00_10; // T
      6'd20:   p = 10'b00_00_10_01_01; // U
      6'd21:   p = 10'b00_10_01_01_01; // V
      6'd22:   p = 10'b00_00_10_10_01; // W
      6'd23:   p = 10'b00_10_01_01_10; // X
      6'd24:   p = 10'b00_10_10_01_10; // Y
      6'd25:   p = 10'b00_01_01_10_10; // Z
      6'd26:   p = 10'b10_10_10_10_10; // 0
      6'd27:   p = 10'b10_10_10_10_01; // 1
      6'd28:   p = 10'b10_10_10_01_01; // 2
      6'd29:   p = 10'b10_10_01_01_01; // 3
      6'd30:   p = 10'b10_01_01_01_01; // 4
      6'd31:   p = 10'b01_01_01_01_01; // 5
      6'd32:   p = 10'b01_01_01_01_10; // 6
      6'd33:   p = 10'b01_01_01_10_10; // 7
      6'd34:   p = 10'b01_01_10_10_10; // 8
      6'd35:   p = 10'b01_10_10_10_10; // 9
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [6:0] index_ascii(input logic [5:0] idx);
    logic [6:0] c;
    if (idx < 6'(NUM_LETTERS)) begin
      c = ASCII_A + 7'(idx);
    end else begin
      c = ASCII_0 + 7'(idx - 6'(NUM_LETTERS));
    end
    return c;
  endfunction

  // Patterns are all distinct, so at most one compare hits.
  function automatic logic [6:0] match_char(input logic [WORD_W-1:0] word);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (word == char_pattern(6'(i))) begin
        c = index_ascii(6'(i));
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/mkd_step.sv
`default_nettype none

module mkd_step
  import mkd_pkg::*;
(
  input  mkd_state_t  state_i,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] duration_i,
  input  logic [6:0]  char_code_i,
  input  logic [15:0] threshold_i,
  output mkd_state_t  state_o,
  output mkd_result_t result_o
);

  logic [SLOT_W-1:0] press_elem;
  logic              is_letter;
  logic              is_digit;
  logic [5:0]        char_idx;
  logic [WORD_W-1:0] load_word;
  logic [WORD_W-1:0] press_word;

  assign press_elem = (duration_i >= threshold_i) ? ELEM_DASH : ELEM_DOT;

  assign is_letter = (char_code_i >= ASCII_A) && (char_code_i < ASCII_A + 7'(NUM_LETTERS));
  assign is_digit  = (char_code_i >= ASCII_0) && (char_code_i < ASCII_0 + 7'(NUM_DIGITS));
  assign char_idx  = is_letter ? 6'(char_code_i - ASCII_A)
                               : 6'(char_code_i - ASCII_0) + 6'(NUM_LETTERS);
  assign load_word = char_pattern(char_idx);

  // Overwrite the slot picked by the fill count.
  always_comb begin
    press_word = state_i.word;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (state_i.count == 3'(i)) begin
        press_word[i*SLOT_W +: SLOT_W] = press_elem;
      end
    end
  end

  always_comb begin
    state_o           = state_i;
    result_o.accepted = 1'b0;
    result_o.element  = ELEM_NONE;
    result_o.rest     = '0;
    unique case (cmd_e'(cmd_i))
      CMD_PRESS: begin
        result_o.element = press_elem;
        if (state_i.count < FULL_COUNT) begin
          state_o.word      = press_word;
          state_o.count     = state_i.count + 3'd1;
          state_o.cleared   = 1'b0;
          result_o.accepted = 1'b1;
        end
      end
      CMD_CLEAR: begin
        state_o.word      = '0;
        state_o.count     = '0;
        state_o.cleared   = 1'b1;
        result_o.accepted = 1'b1;
      end
      CMD_LOAD: begin
        if (is_letter || is_digit) begin
          state_o.word      = load_word;
          state_o.count     = '0;
          state_o.cleared   = 1'b0;
          result_o.accepted = 1'b1;
          result_o.element  = load_word[SLOT_W-1:0];
          result_o.rest     = load_word[WORD_W-1:SLOT_W];
        end
      end
      default: ;
    endcase
    result_o.count   = state_o.count;
    result_o.cleared = state_o.cleared;
    result_o.matched = match_char(state_o.word);
  end

endmodule

`default_nettype wire

### src/morse_key_decoder_core.sv
// Morse key decoder core.
// Input channel (in_valid_i / in_stall_o): each beat carries cmd_i, duration_i and
// char_code_i. A key press becomes a dot or a dash against the dash threshold and is
// appended to a five-slot code word; a clear empties the word; a load of A-Z or 0-9
// places that character's pattern in the word and sends its elements as a run.
// Output channel (out_valid_o / out_stall_i): one beat per press, clear or rejected
// item, one beat per element of a loaded pattern, last_o marking the final one.
// Configuration channel (cfg_valid_i / cfg_ready_o): always ready; each beat writes
// the 16-bit dash threshold. Write it only while the block is idle.
// An accepted beat is held in the input register; its first result is then loaded
// into the output register once that register is free, and leaves from there.
// One item per cycle while the receiver does not stall; a load holds the input side
// until its run of elements has drained from the output register.
// A stalled receiver freezes the output register; an input beat still lands in the
// input register if that register is empty, after which in_stall_o rises.
// Reset: empty word, count zero, cleared flag set, threshold back to 200, both
// registers empty.
`default_nettype none

module morse_key_decoder_core
  import mkd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] duration_i,
  input  logic [6:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [1:0]  element_o,
  output logic        last_o,
  output logic [2:0]  element_count_o,
  output logic        full_res_o,
  output logic        cleared_o,
  output logic [6:0]  matched_char_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] thresh_q;

  // Input register
  logic        in_valid_q, in_valid_d;
  logic [1:0]  cmd_q;
  logic [15:0] duration_q;
  logic [6:0]  char_code_q;

  // Architectural state
  mkd_state_t state_q, state_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  mkd_result_t out_q, out_d;
  mkd_result_t step_res;

  logic in_take;
  logic out_fire;
  logic out_last;
  logic out_free;
  logic advance;

  // Output side: a beat leaves when valid and not stalled; the item is done on last.
  assign out_last = (out_q.rest[SLOT_W-1:0] == ELEM_NONE);
  assign out_fire = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || (out_fire && out_last);

  // Move the held item into the output register when that register frees up.
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !advance);

  mkd_step u_step (
    .state_i     (state_q),
    .cmd_i       (cmd_q),
    .duration_i  (duration_q),
    .char_code_i (char_code_q),
    .threshold_i (thresh_q),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  // Load a new result, or shift the next element of a run out of rest.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_d       = step_res;
      out_valid_d = 1'b1;
    end else if (out_fire && !out_last) begin
      out_d.element = out_q.rest[SLOT_W-1:0];
      out_d.rest    = out_q.rest >> SLOT_W;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q      <= THRESH_RESET;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.word    <= '0;
      state_q.count   <= '0;
      state_q.cleared <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q       <= cmd_i;
      duration_q  <= duration_i;
      char_code_q <= char_code_i;
    end
    out_q <= out_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_q.accepted;
  assign element_o       = out_q.element;
  assign last_o          = out_last;
  assign element_count_o = out_q.count;
  assign full_res_o      = (out_q.count == FULL_COUNT);
  assign cleared_o       = out_q.cleared;
  assign matched_char_o  = out_q.matched;

  // Fill count never runs past the last slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= FULL_COUNT)
    else $error("fill count beyond five slots");

  // A cleared word is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cleared |-> (state_q.count == '0) && (state_q.word == '0))
    else $error("cleared flag set on a non-empty word");

  // No new item enters the output register while a run is still draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last |-> !advance)
    else $error("item advanced over an unfinished run");

  // A beat with no element is always the only beat of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (element_o == ELEM_NONE) |-> last_o)
    else $error("empty element inside a run");

endmodule

`default_nettype wire
